// ----- rtl/aescm_pkg.sv -----
// ----------------------------------------------------------------------------
// AES-128 CMAC package
// Shared payload types, control structs and AES helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aescm_pkg;

    localparam int unsigned ROUNDS     = 10;
    localparam int unsigned RK_WORDS   = 22;
    localparam int unsigned RK_AW      = 5;
    localparam int unsigned ROUND_W    = 4;
    localparam int unsigned VBYTES_W   = 5;
    localparam int unsigned BLOCK_BYTES = 16;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] DBL_POLY  = 8'h87;

    // Configuration register byte addresses
    localparam logic [3:0] ADDR_KEY_UPPER = 4'h0;
    localparam logic [3:0] ADDR_KEY_LOWER = 4'h8;

    typedef struct packed {
        logic [63:0]         block_upper;
        logic [63:0]         block_lower;
        logic [VBYTES_W-1:0] valid_bytes;
        logic                final_block;
    } t_in_word;

    typedef struct packed {
        logic [63:0] tag_upper;
        logic [63:0] tag_lower;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic                 key_load;   // load round key 0 from key regs
        logic                 key_step;   // compute next round key
        logic                 load_zero;  // state <= rk0 (zero block)
        logic                 load_msg;   // state <= prepared message ^ chain ^ rk0
        logic                 round;      // one AES round
        logic [ROUND_W-1:0]   round_idx;  // 1..10
        logic                 save_sub;   // derive subkeys from state
        logic                 save_chain; // chain <= state
        logic                 clr_chain;  // chain <= 0
        logic                 save_tag;   // output reg <= state
    } t_dp_cmd;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [0:255];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] r);
        logic [7:0] v;
        case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // 128-bit doubling in GF(2^128)
    function automatic logic [127:0] dbl(input logic [127:0] x);
        return {x[126:0], 1'b0} ^ {120'd0, (x[127] ? DBL_POLY : 8'h00)};
    endfunction

    // Byte i of a 128-bit block, byte 0 most significant
    function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

endpackage

// ----- rtl/aescm_ctrl.sv -----
// ----------------------------------------------------------------------------
// AES-128 CMAC controller
// Sequences subkey preparation, block encryption and result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aescm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_final,
    input  logic                i_key_write,
    input  logic                i_out_busy,   // output register holds a word
    output aescm_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_KEY   = 3'd1;  // expand key and encrypt zero block
    localparam logic [2:0] S_SUB   = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_ENC   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                      r_state, n_state;
    logic [aescm_pkg::ROUND_W-1:0]   r_round, n_round;
    logic                            r_ready, n_ready;  // subkeys valid
    logic                            r_final, n_final;

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_ready = r_ready;
        n_final = r_final;
        o_cmd   = '0;
        o_cmd.round_idx = r_round;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_final = i_final;
                    if (r_ready) begin
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.key_load  = 1'b1;
                        o_cmd.load_zero = 1'b1;
                        n_round = 4'd1;
                        n_state = S_KEY;
                    end
                end
            end
            S_KEY: begin
                o_cmd.round    = 1'b1;
                o_cmd.key_step = 1'b1;
                n_round = r_round + 4'd1;
                if (r_round == 4'(aescm_pkg::ROUNDS)) begin
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                o_cmd.save_sub = 1'b1;
                n_ready = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_msg = 1'b1;
                n_round = 4'd1;
                n_state = S_ENC;
            end
            S_ENC: begin
                o_cmd.round = 1'b1;
                n_round = r_round + 4'd1;
                if (r_round == 4'(aescm_pkg::ROUNDS)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_final) begin
                    o_cmd.save_chain = 1'b1;
                    n_state = S_IDLE;
                end else if (!i_out_busy) begin
                    o_cmd.save_tag  = 1'b1;
                    o_cmd.clr_chain = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_key_write) begin
            n_ready = 1'b0;
            o_cmd.clr_chain = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_ready <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_ready <= n_ready;
            r_final <= n_final;
        end
    end

endmodule

// ----- rtl/aescm_dp.sv -----
// ----------------------------------------------------------------------------
// AES-128 CMAC datapath
// Round key store, one-round AES unit, subkeys, chain value, tag register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aescm_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aescm_pkg::t_dp_cmd   i_cmd,
    input  logic [127:0]         i_key,
    input  logic                 i_in_fire,
    input  aescm_pkg::t_in_word  i_in,
    output aescm_pkg::t_out_word o_out,
    output logic                 o_out_valid,
    input  logic                 i_out_ready
);

    // Round key store: two 64-bit words per round key
    logic [63:0] r_rk_mem [0:aescm_pkg::RK_WORDS-1];
    logic [127:0] r_rk;        // round key being generated during expansion
    logic [127:0] r_rk_rd;     // registered read of the store
    logic [127:0] r_state;
    logic [127:0] r_chain, r_k1, r_k2;
    aescm_pkg::t_in_word r_msg;
    aescm_pkg::t_out_word r_out;
    logic r_out_valid;

    logic [127:0] n_rk, round_key, sb, sr, mc, round_out, prep, rk0;
    logic [aescm_pkg::RK_AW-1:0] rd_addr;
    logic [4:0] nv;

    // Next round key from current one
    always_comb begin
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t = {aescm_pkg::sbox(r_rk[23:16]), aescm_pkg::sbox(r_rk[15:8]),
             aescm_pkg::sbox(r_rk[7:0]), aescm_pkg::sbox(r_rk[31:24])};
        t = t ^ {aescm_pkg::rcon(i_cmd.round_idx), 24'd0};
        w0 = r_rk[127:96] ^ t;
        w1 = r_rk[95:64] ^ w0;
        w2 = r_rk[63:32] ^ w1;
        w3 = r_rk[31:0] ^ w2;
        n_rk = {w0, w1, w2, w3};
    end

    // During expansion the key comes straight from the generator; otherwise
    // from the store, through its registered read, addressed ahead of use.
    assign round_key = i_cmd.key_step ? n_rk : r_rk_rd;
    assign rk0 = i_cmd.key_load ? i_key : r_rk_rd;

    always_comb begin
        rd_addr = '0;
        if (i_cmd.round) begin
            rd_addr = aescm_pkg::RK_AW'({1'b0, i_cmd.round_idx} + 5'd1);
        end else if (i_cmd.load_msg) begin
            rd_addr = 5'd1;
        end
    end

    // One AES round
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sb[127-8*i -: 8] = aescm_pkg::sbox(aescm_pkg::byte_of(r_state, i));
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                sr[127-8*(c*4+i) -: 8] = aescm_pkg::byte_of(sb, ((c + i) % 4) * 4 + i);
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = aescm_pkg::byte_of(sr, c*4);
            a1 = aescm_pkg::byte_of(sr, c*4+1);
            a2 = aescm_pkg::byte_of(sr, c*4+2);
            a3 = aescm_pkg::byte_of(sr, c*4+3);
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[127-32*c -: 32] = {a0 ^ al ^ aescm_pkg::xtime(a0 ^ a1),
                                  a1 ^ al ^ aescm_pkg::xtime(a1 ^ a2),
                                  a2 ^ al ^ aescm_pkg::xtime(a2 ^ a3),
                                  a3 ^ al ^ aescm_pkg::xtime(a3 ^ a0)};
        end
        round_out = ((i_cmd.round_idx == 4'(aescm_pkg::ROUNDS)) ? sr : mc) ^ round_key;
    end

    // Message preparation: pad and mask with subkey for a final block
    always_comb begin
        logic [127:0] m;
        nv = (r_msg.valid_bytes > 5'd16) ? 5'd16 : r_msg.valid_bytes;
        m  = {r_msg.block_upper, r_msg.block_lower};
        if (!r_msg.final_block) begin
            prep = m;
        end else if (nv == 5'd16) begin
            prep = m ^ r_k1;
        end else begin
            for (int i = 0; i < 16; i++) begin
                if (i == int'(nv)) begin
                    prep[127-8*i -: 8] = aescm_pkg::PAD_BYTE;
                end else if (i > int'(nv)) begin
                    prep[127-8*i -: 8] = 8'h00;
                end else begin
                    prep[127-8*i -: 8] = aescm_pkg::byte_of(m, i);
                end
            end
            prep = prep ^ r_k2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rk_rd <= {r_rk_mem[{rd_addr[3:0], 1'b0}], r_rk_mem[{rd_addr[3:0], 1'b1}]};
        if (i_in_fire) begin
            r_msg <= i_in;
        end
        if (i_cmd.key_load) begin
            r_rk <= i_key;
            r_rk_mem[0] <= i_key[127:64];
            r_rk_mem[1] <= i_key[63:0];
        end else if (i_cmd.key_step) begin
            r_rk <= n_rk;
            r_rk_mem[{i_cmd.round_idx, 1'b0}] <= n_rk[127:64];
            r_rk_mem[{i_cmd.round_idx, 1'b1}] <= n_rk[63:0];
        end
        if (i_cmd.load_zero) begin
            r_state <= rk0;
        end else if (i_cmd.load_msg) begin
            r_state <= prep ^ r_chain ^ rk0;
        end else if (i_cmd.round) begin
            r_state <= round_out;
        end
        if (i_cmd.save_sub) begin
            r_k1 <= aescm_pkg::dbl(r_state);
            r_k2 <= aescm_pkg::dbl(aescm_pkg::dbl(r_state));
        end
        if (i_cmd.save_tag) begin
            r_out <= {r_state[127:64], r_state[63:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_chain) begin
                r_chain <= '0;
            end else if (i_cmd.save_chain) begin
                r_chain <= r_state;
            end
            if (i_cmd.save_tag) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/aes128_cmac_engine_core.sv -----
// ----------------------------------------------------------------------------
// AES-128 CMAC engine
// Computes an RFC 4493 MAC over a stream of 16-byte words.
// ----------------------------------------------------------------------------
// Per word: from acceptance, load, ten rounds on the one-round AES unit and
//   finish, ending in a chain update or a tag in the output register.
// The first word after reset or a key write first goes through key expansion,
//   zero-block encryption and subkey derivation.
// A new word is taken only once the last is done; a tag waits for output room.
// Reset: synchronous active low; clears key, chain value and subkey flag.
`timescale 1ns / 1ps

module aes128_cmac_engine_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  i_valid,
    output logic                  o_ready,
    input  aescm_pkg::t_in_word   i_data,
    // result words
    output logic                  o_valid,
    input  logic                  i_ready,
    output aescm_pkg::t_out_word  o_data,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);

    logic [63:0] r_key_upper, r_key_lower;
    logic        wr_en, key_write, in_fire;
    aescm_pkg::t_dp_cmd cmd;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    // Any key write invalidates the subkeys and abandons a message in flight
    assign key_write = wr_en && (paddr == aescm_pkg::ADDR_KEY_UPPER ||
                                 paddr == aescm_pkg::ADDR_KEY_LOWER);
    assign in_fire   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
        end else if (wr_en) begin
            unique case (paddr)
                aescm_pkg::ADDR_KEY_UPPER: r_key_upper <= pwdata;
                aescm_pkg::ADDR_KEY_LOWER: r_key_lower <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            aescm_pkg::ADDR_KEY_UPPER: prdata = r_key_upper;
            aescm_pkg::ADDR_KEY_LOWER: prdata = r_key_lower;
            default:                   prdata = '0;
        endcase
    end

    aescm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_final     (i_data.final_block),
        .i_key_write (key_write),
        .i_out_busy  (o_valid && !i_ready),
        .o_cmd       (cmd)
    );

    aescm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_key       ({r_key_upper, r_key_lower}),
        .i_in_fire   (in_fire),
        .i_in        (i_data),
        .o_out       (o_data),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready)
    );

endmodule

// ----- verif/tb_aes128_cmac_engine_core.sv -----
// ----------------------------------------------------------------------------
// AES-128 CMAC engine testbench
// Drives message words through the valid/ready input, programs the key over
// the APB-style port; checks tags by known vectors or a built-in CMAC model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_aes128_cmac_engine_core;

    localparam int unsigned DRAIN_CYCLES  = 40;   // two AES passes plus margin
    localparam int unsigned CALM_AFTER    = 560;  // words before idling stops

    localparam logic [7:0] SUB_TABLE [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] ROUND_CONST [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

    // Well-known test key and vectors for the directed part
    localparam logic [127:0] STD_KEY       = 128'h2b7e151628aed2a6abf7158809cf4f3c;
    localparam logic [127:0] STD_MSG       = 128'h6bc1bee22e409f96e93d7e117393172a;
    localparam logic [127:0] STD_TAG_EMPTY = 128'hbb1d6929e95937287fa37d129b756746;
    localparam logic [127:0] STD_TAG_ONE   = 128'h070a16b46b4d4144f79bdd9dd04a287c;

    typedef struct {
        aescm_pkg::t_in_word word;
        bit                  known;
        logic [127:0]        tag;
    } t_stim_row;

    // DUT signals; the driven inputs are known from time zero
    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    aescm_pkg::t_in_word  i_data  = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    aescm_pkg::t_out_word o_data;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [3:0]           paddr   = '0;
    logic [63:0]          pwdata  = '0;
    logic [63:0]          prdata;
    logic                 pready;

    // Predictor state
    logic [127:0] key_value;
    logic [127:0] chain_value;
    logic [127:0] subkey_full;
    logic [127:0] subkey_pad;
    bit           subkeys_valid;
    logic [127:0] round_keys [11];

    logic [127:0] pending_tags [$];
    t_stim_row    directed_rows [$];
    int unsigned  error_count = 0;
    int unsigned  words_sent  = 0;
    bit           calm        = 1'b0;
    int unsigned  ready_stall = 0;

    aes128_cmac_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // AES-128 predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] sub_word(input logic [31:0] x);
        return {SUB_TABLE[x[31:24]], SUB_TABLE[x[23:16]],
                SUB_TABLE[x[15:8]], SUB_TABLE[x[7:0]]};
    endfunction

    function automatic logic [7:0] gf_double_byte(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] gf_double_block(input logic [127:0] x);
        return {x[126:0], 1'b0} ^ {120'd0, (x[127] ? 8'h87 : 8'h00)};
    endfunction

    task automatic expand_round_keys();
        logic [31:0] w [44];
        logic [31:0] t;
        int i;
        for (i = 0; i < 4; i++)
            w[i] = key_value[127-32*i -: 32];
        for (i = 4; i < 44; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                // rotate, substitute, add round constant
                t = sub_word({t[23:0], t[31:24]}) ^ {ROUND_CONST[i/4-1], 24'd0};
            end
            w[i] = w[i-4] ^ t;
        end
        for (i = 0; i < 11; i++)
            round_keys[i] = {w[4*i], w[4*i+1], w[4*i+2], w[4*i+3]};
    endtask

    function automatic logic [127:0] aes_encrypt(input logic [127:0] plain);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, mix;
        logic [127:0] st;
        int r, c, i;
        st = plain ^ round_keys[0];
        for (r = 1; r <= 10; r++) begin
            for (i = 0; i < 16; i++)
                s[i] = SUB_TABLE[st[127-8*i -: 8]];
            for (c = 0; c < 4; c++)
                for (i = 0; i < 4; i++)
                    t[c*4+i] = s[((c+i)%4)*4+i];
            for (c = 0; c < 4; c++) begin
                if (r != 10) begin
                    a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
                    mix = a0 ^ a1 ^ a2 ^ a3;
                    s[c*4]   = a0 ^ mix ^ gf_double_byte(a0 ^ a1);
                    s[c*4+1] = a1 ^ mix ^ gf_double_byte(a1 ^ a2);
                    s[c*4+2] = a2 ^ mix ^ gf_double_byte(a2 ^ a3);
                    s[c*4+3] = a3 ^ mix ^ gf_double_byte(a3 ^ a0);
                end else begin
                    for (i = 0; i < 4; i++)
                        s[c*4+i] = t[c*4+i];
                end
            end
            for (i = 0; i < 16; i++)
                st[127-8*i -: 8] = s[i];
            st = st ^ round_keys[r];
        end
        return st;
    endfunction

    // Absorb one message word; give back a tag when it closes the message.
    task automatic cmac_absorb(input aescm_pkg::t_in_word w, output bit has_tag,
                               output logic [127:0] tag);
        logic [127:0] m;
        logic [127:0] c;
        int nbytes, i;
        nbytes = (w.valid_bytes > 16) ? 16 : int'(w.valid_bytes);
        if (!subkeys_valid) begin
            expand_round_keys();
            subkey_full   = gf_double_block(aes_encrypt('0));
            subkey_pad    = gf_double_block(subkey_full);
            subkeys_valid = 1'b1;
        end
        m = {w.block_upper, w.block_lower};
        if (w.final_block) begin
            if (nbytes == 16) begin
                m = m ^ subkey_full;
            end else begin
                // pad: marker byte, then zeros to the end
                for (i = nbytes; i < 16; i++)
                    m[127-8*i -: 8] = (i == nbytes) ? 8'h80 : 8'h00;
                m = m ^ subkey_pad;
            end
        end
        c = aes_encrypt(m ^ chain_value);
        has_tag = w.final_block;
        tag = c;
        chain_value = w.final_block ? '0 : c;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_tags.size() == 0) begin
                report_mismatch("tag with no message pending", o_data.tag_upper, 64'd0);
            end else begin
                if (o_data.tag_upper !== pending_tags[0][127:64])
                    report_mismatch("tag_upper", o_data.tag_upper, pending_tags[0][127:64]);
                if (o_data.tag_lower !== pending_tags[0][63:0])
                    report_mismatch("tag_lower", o_data.tag_lower, pending_tags[0][63:0]);
                void'(pending_tags.pop_front());
            end
        end
    end

    // Result side: stall in random bursts; no new burst starts once calm.
    always @(posedge i_clk) begin
        if (ready_stall > 0) begin
            ready_stall <= ready_stall - 1;
            i_ready     <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            ready_stall <= $urandom_range(1, 9) - 1;
            i_ready     <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Write one key register; only call while the engine is drained.
    task automatic write_key(input logic [3:0] addr, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == aescm_pkg::ADDR_KEY_UPPER)
            key_value[127:64] = value;
        else
            key_value[63:0] = value;
        subkeys_valid = 1'b0;
        chain_value   = '0;
        // hold the bus idle before the next transfer
        @(posedge i_clk);
    endtask

    // Wait until every tag is in, then let a chained word finish too.
    task automatic drain();
        while (pending_tags.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Offer one word; hold valid and payload until it is taken.
    task automatic send_word(input aescm_pkg::t_in_word w, input bit known,
                             input logic [127:0] known_tag);
        bit has_tag;
        logic [127:0] tag;
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        cmac_absorb(w, has_tag, tag);
        if (has_tag)
            pending_tags.push_back(known ? known_tag : tag);
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
        if (words_sent >= CALM_AFTER)
            calm = 1'b1;
    endtask

    function automatic aescm_pkg::t_in_word make_word(input logic [127:0] blk,
                                                      input int unsigned nbytes,
                                                      input bit last);
        aescm_pkg::t_in_word w;
        w.block_upper = blk[127:64];
        w.block_lower = blk[63:0];
        w.valid_bytes = nbytes[4:0];
        w.final_block = last;
        return w;
    endfunction

    task automatic add_row(input logic [127:0] blk, input int unsigned nbytes,
                           input bit last, input bit known, input logic [127:0] tag);
        t_stim_row r;
        r.word  = make_word(blk, nbytes, last);
        r.known = known;
        r.tag   = tag;
        directed_rows.push_back(r);
    endtask

    // Random message: a few chained words, last one with a random length.
    task automatic send_random_message();
        int unsigned len, k, nbytes;
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
            if (k == len - 1) begin
                // mostly legal lengths, sometimes above a full word
                nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31)
                                                     : $urandom_range(0, 16);
                send_word(make_word({$urandom, $urandom, $urandom, $urandom}, nbytes, 1'b1),
                          1'b0, '0);
            end else begin
                send_word(make_word({$urandom, $urandom, $urandom, $urandom},
                                    $urandom_range(0, 31), 1'b0), 1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [127:0] new_key;
        int phase, n;
        int unsigned target;
        key_value     = '0;
        chain_value   = '0;
        subkey_full   = '0;
        subkey_pad    = '0;
        subkeys_valid = 1'b0;

        // hold reset, then release at an edge
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset key of zero: the empty message right away
        send_word(make_word('0, 0, 1'b1), 1'b0, '0);
        i_valid <= 1'b0;
        drain();

        write_key(aescm_pkg::ADDR_KEY_UPPER, STD_KEY[127:64]);
        write_key(aescm_pkg::ADDR_KEY_LOWER, STD_KEY[63:0]);

        // directed table: known vectors, length extremes, ignored bytes
        add_row('1,      0,  1'b1, 1'b1, STD_TAG_EMPTY);
        add_row(STD_MSG, 16, 1'b1, 1'b1, STD_TAG_ONE);
        add_row('1,      0,  1'b0, 1'b0, '0);
        add_row('0,      31, 1'b1, 1'b0, '0);
        add_row('0,      16, 1'b0, 1'b0, '0);
        add_row('1,      1,  1'b1, 1'b0, '0);
        add_row(STD_MSG, 15, 1'b1, 1'b0, '0);
        add_row('1,      16, 1'b1, 1'b0, '0);
        add_row(STD_MSG, 31, 1'b0, 1'b0, '0);
        add_row(STD_MSG, 7,  1'b0, 1'b0, '0);
        add_row('1,      17, 1'b1, 1'b0, '0);
        add_row('0,      0,  1'b1, 1'b0, '0);
        add_row({64'h8000000000000000, 64'h1}, 8, 1'b1, 1'b0, '0);
        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].tag);

        // leave a message open, so the next key write abandons it
        send_word(make_word(STD_MSG, 16, 1'b0), 1'b0, '0);
        i_valid <= 1'b0;

        // random phases, each under a new key
        for (phase = 0; phase < 9; phase++) begin
            drain();
            case (phase % 5)
                0:       new_key = '1;
                1:       new_key = '0;
                2:       new_key = STD_KEY;
                default: new_key = {$urandom, $urandom, $urandom, $urandom};
            endcase
            // sometimes rewrite only one half of the key
            if (phase == 4 || phase == 7) begin
                write_key(aescm_pkg::ADDR_KEY_LOWER, new_key[63:0]);
            end else begin
                write_key(aescm_pkg::ADDR_KEY_UPPER, new_key[127:64]);
                write_key(aescm_pkg::ADDR_KEY_LOWER, new_key[63:0]);
            end
            target = words_sent + 70;
            n = 0;
            while (words_sent < target) begin
                send_random_message();
                n++;
            end
            // drop valid between phases; back-to-back words keep it high
            i_valid <= 1'b0;
        end

        // finish: wait for every tag, then let the engine settle
        drain();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/aescm_pkg.sv
rtl/aescm_ctrl.sv
rtl/aescm_dp.sv
rtl/aes128_cmac_engine_core.sv
verif/tb_aes128_cmac_engine_core.sv
